// ----- rtl/bfth_pkg.sv -----
package bfth_pkg;

	// fixed field and hash widths
	localparam int SIZE_W = 13;
	localparam int HASH_W = 32;
	localparam int CHAR_W = 8;

	// polynomial hash multipliers
	localparam logic [HASH_W-1:0] SEED_A = 32'd17;
	localparam logic [HASH_W-1:0] SEED_B = 32'd29;

	// defaults
	localparam int               DEF_MAX_BITS = 4096;
	localparam logic [SIZE_W-1:0] DEF_SET_SIZE = 13'd4096;

	// operation codes carried in tuser
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_ADD    = 1'b1;

endpackage

// ----- rtl/bloom_filter_two_hash_unit.sv -----
// Two-hash Bloom filter over byte strings. A string streams in one byte per word on the slave
// side (tdata = signed character, tuser = {empty_req, operation}, tlast ends the string); bytes
// are absorbed into the two 32-bit hashes (x17 and x29) at one word per clock while idle. On the
// last word the block stops taking input: a step forms the hash magnitudes and the modulus,
// the shared-step restoring remainder then runs (one dividend bit per cycle, both hashes side
// by side), then the single-port bit memory takes two accesses, and a lookup registers its
// result in a last step that stretches for as long as an earlier result word is still held on
// the master side. A lookup returns one word on the master side (tdata bit 0 = found); an add
// returns nothing. After reset the bit memory is cleared one bit per cycle, and no word is taken
// meanwhile. set_size is written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle (the block does not enforce this), and it applies from the next last word.
module bloom_filter_two_hash_unit #(
	parameter int MAX_BITS = bfth_pkg::DEF_MAX_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: set_size
	input  logic                        cfg_we,
	input  logic [bfth_pkg::SIZE_W-1:0] cfg_wdata,
	// slave stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] char_byte (signed)
	input  logic                        s_tlast,
	input  logic [1:0]                  s_tuser,   // [0] operation, [1] empty_req
	// master stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata    // [0] found, [7:1] zero
);

	localparam int IW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
	localparam int SW = bfth_pkg::SIZE_W;
	localparam int HW = bfth_pkg::HASH_W;
	localparam int CW = $clog2(HW);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MAG,
		S_DIV,
		S_ACC_A,
		S_ACC_B,
		S_FIN
	} state_t;

	state_t         state_q;
	logic [IW-1:0]  clr_cnt_q;
	logic [CW-1:0]  div_cnt_q;
	logic [HW-1:0]  hash_a_q, hash_b_q;
	logic [SW-1:0]  rem_a_q, rem_b_q;
	logic [SW-1:0]  mod_q;
	logic [SW-1:0]  set_size_q;
	logic           op_q;
	logic           bit_a_q;
	logic           m_tvalid_q;
	logic           found_q;

	// memory port
	logic           mem_we;
	logic [IW-1:0]  mem_addr;
	logic           mem_wdata;
	logic           rd_q;
	logic           bit_mem [MAX_BITS];

	// byte absorb
	logic           s_fire;
	logic [HW-1:0]  char_ext;
	logic [HW-1:0]  hash_a_nxt, hash_b_nxt;

	// remainder step
	logic [SW:0]    rem_a_sh, rem_b_sh;
	logic [SW:0]    mod_ext;
	logic [SW:0]    rem_a_nxt, rem_b_nxt;

	// modulus clamp
	logic [SW-1:0]  mod_nxt;

	// remainder to memory index
	logic [31:0]    idx_a_ext, idx_b_ext;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, found_q};

	// sign-extended character and hash update
	assign char_ext   = {{(HW-bfth_pkg::CHAR_W){s_tdata[7]}}, s_tdata};
	assign hash_a_nxt = hash_a_q * bfth_pkg::SEED_A + char_ext;
	assign hash_b_nxt = hash_b_q * bfth_pkg::SEED_B + char_ext;

	// one restoring step per cycle, dividend bit taken from hash MSB
	always_comb begin
		mod_ext  = {1'b0, mod_q};
		rem_a_sh = {rem_a_q, hash_a_q[HW-1]};
		rem_b_sh = {rem_b_q, hash_b_q[HW-1]};
		rem_a_nxt = (rem_a_sh >= mod_ext) ? (rem_a_sh - mod_ext) : rem_a_sh;
		rem_b_nxt = (rem_b_sh >= mod_ext) ? (rem_b_sh - mod_ext) : rem_b_sh;
	end

	// modulus: zero reads as one, clamp to store size
	always_comb begin
		mod_nxt = set_size_q;
		if (set_size_q == '0) begin
			mod_nxt = SW'(1);
		end else if (32'(set_size_q) > 32'(MAX_BITS)) begin
			mod_nxt = SW'(MAX_BITS);
		end
	end

	assign idx_a_ext = 32'(rem_a_q);
	assign idx_b_ext = 32'(rem_b_q);

	// memory port select
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 1'b1;
		mem_addr  = idx_b_ext[IW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = 1'b0;
				mem_addr  = clr_cnt_q;
			end
			S_ACC_A: begin
				mem_we   = (op_q == bfth_pkg::OP_ADD);
				mem_addr = idx_a_ext[IW-1:0];
			end
			S_ACC_B: begin
				mem_we   = (op_q == bfth_pkg::OP_ADD);
				mem_addr = idx_b_ext[IW-1:0];
			end
			default: begin
				mem_addr = idx_b_ext[IW-1:0];
			end
		endcase
	end

	// bit store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bit_mem[mem_addr] <= mem_wdata;
		end
		rd_q <= bit_mem[mem_addr];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= bfth_pkg::DEF_SET_SIZE;
		end else if (cfg_we) begin
			set_size_q <= cfg_wdata;
		end
	end

	// sequencer, hashes, remainders and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			div_cnt_q  <= '0;
			hash_a_q   <= '0;
			hash_b_q   <= '0;
			rem_a_q    <= '0;
			rem_b_q    <= '0;
			mod_q      <= SW'(1);
			op_q       <= bfth_pkg::OP_LOOKUP;
			bit_a_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			// S_FIN drives the valid flag itself
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + IW'(1);
					if (clr_cnt_q == IW'(MAX_BITS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_fire) begin
						if (!s_tuser[1]) begin
							hash_a_q <= hash_a_nxt;
							hash_b_q <= hash_b_nxt;
						end
						if (s_tlast) begin
							op_q    <= s_tuser[0];
							state_q <= S_MAG;
						end
					end
				end
				S_MAG: begin
					// magnitude; most negative value wraps to 2^31 unsigned
					if (hash_a_q[HW-1]) begin
						hash_a_q <= -hash_a_q;
					end
					if (hash_b_q[HW-1]) begin
						hash_b_q <= -hash_b_q;
					end
					mod_q     <= mod_nxt;
					rem_a_q   <= '0;
					rem_b_q   <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// shifting out the dividend leaves the hashes cleared
					rem_a_q   <= rem_a_nxt[SW-1:0];
					rem_b_q   <= rem_b_nxt[SW-1:0];
					hash_a_q  <= {hash_a_q[HW-2:0], 1'b0};
					hash_b_q  <= {hash_b_q[HW-2:0], 1'b0};
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_cnt_q == CW'(HW - 1)) begin
						state_q <= S_ACC_A;
					end
				end
				S_ACC_A: begin
					state_q <= S_ACC_B;
				end
				S_ACC_B: begin
					bit_a_q <= rd_q;
					state_q <= (op_q == bfth_pkg::OP_ADD) ? S_IDLE : S_FIN;
				end
				S_FIN: begin
					// rd_q holds the second bit while the address stays put
					if (!m_tvalid_q || m_tready) begin
						found_q    <= bit_a_q & rd_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// a result word only appears after a lookup finishes
	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_FIN && op_q == bfth_pkg::OP_LOOKUP))
		else $error("result word without a lookup");

	// both indexes lie inside the modulus when the store is accessed
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC_A) |-> (rem_a_q < mod_q && rem_b_q < mod_q))
		else $error("bit index beyond modulus");

	// hashes are cleared once the remainder pass ends
	a_hash_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC_A) |-> (hash_a_q == '0 && hash_b_q == '0))
		else $error("hash not cleared after string");

	// a last word starts the magnitude step
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_tlast) |=> (state_q == S_MAG))
		else $error("last word not followed by index computation");

	// the modulus is never zero
	a_mod_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (mod_q != '0))
		else $error("zero modulus");
`endif

endmodule
